>>> hdl/separable_hole_fill_interpolator_core_assert.svh
// Assertion macros used by the checker file of the hole fill core.
`ifndef SEPARABLE_HOLE_FILL_INTERPOLATOR_CORE_ASSERT_SVH
`define SEPARABLE_HOLE_FILL_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define SFI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hole fill core check failed");

// Next-cycle implication.
`define SFI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hole fill core check failed");

`endif

>>> hdl/sfi_pkg.sv
// Shared types and constants of the hole fill core.
package sfi_pkg;

   localparam int CSR_DATA_BITS  = 9;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } fill_status_type;

endpackage

>>> hdl/sfi_frame_ram.sv
// Frame store: one write port, one read port, registered read data.
module sfi_frame_ram #(
   parameter int ADDR_BITS = 16,
   parameter int DATA_BITS = 17
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [DATA_BITS-1:0] wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [DATA_BITS-1:0] rdata
);
   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hdl/sfi_divider.sv
// Restoring divider, one quotient bit per cycle.
module sfi_divider #(
   parameter int NUM_BITS = 16,
   parameter int DEN_BITS = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient,
   output logic [DEN_BITS-1:0] remainder
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [NUM_BITS-1:0] quo_ff;
   logic [DEN_BITS-1:0] rem_ff;
   logic [DEN_BITS:0]   partial_in;
   logic [DEN_BITS:0]   diff_in;
   logic                ge_in;

   assign partial_in = {rem_ff, quo_ff[NUM_BITS-1]};
   assign ge_in      = partial_in >= {1'b0, divisor};
   assign diff_in    = partial_in - {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(NUM_BITS);
            quo_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= ge_in ? diff_in[DEN_BITS-1:0] : partial_in[DEN_BITS-1:0];
            quo_ff <= {quo_ff[NUM_BITS-2:0], ge_in};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

>>> hdl/sfi_fill_engine.sv
// Fill sequencer: row pass then column pass over the frame store.
module sfi_fill_engine #(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]      width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]     height,
   output sfi_pkg::fill_status_type            status,
   output logic                                mem_we,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] mem_waddr,
   output logic [SAMPLE_BITS:0]                mem_wdata,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] mem_raddr,
   input  logic [SAMPLE_BITS:0]                mem_rdata
);
   import sfi_pkg::*;

   localparam int SB   = SAMPLE_BITS;
   localparam int AW   = $clog2(MAX_WIDTH*MAX_HEIGHT);
   localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DW   = $clog2(MAXD + 1);
   localparam int LW   = $clog2(MAXD + 2);
   localparam int RW   = LW + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_LINE_INIT, S_RD, S_EV, S_DIV_START, S_DIV_WAIT, S_WR, S_LINE_NEXT, S_DONE
   } state_type;

   state_type              state_ff;
   logic                   pass_ff;
   logic [DW-1:0]          line_ff;
   logic [AW-1:0]          base_ff;
   logic [DW-1:0]          pos_ff;
   logic [AW-1:0]          addr_ff;
   logic                   has_l_ff;
   logic signed [SB-1:0]   f_ff;
   logic                   in_run_ff;
   logic [AW-1:0]          run_addr_ff;
   logic [DW-1:0]          run_len_ff;
   logic                   end_line_ff;
   logic signed [SB-1:0]   fbase_ff;
   logic [SB-1:0]          mag_ff;
   logic                   neg_ff;
   logic [SB:0]            q_ff;
   logic [RW-1:0]          r_ff;
   logic [AW-1:0]          k_addr_ff;
   logic [DW-1:0]          k_cnt_ff;

   logic [DW-1:0]          n_in;
   logic [DW-1:0]          lines_in;
   logic [AW-1:0]          stride_in;
   logic [AW-1:0]          base_step_in;
   logic                   pix_ok_in;
   logic signed [SB-1:0]   pix_val_in;
   logic signed [SB:0]     diff_in;
   logic [SB:0]            abs_in;
   logic                   last_pos_in;
   logic [LW-1:0]          den_in;
   logic [RW-1:0]          twice_den_in;
   logic                   div_done;
   logic [SB-1:0]          q0;
   logic [LW-1:0]          rem0;
   logic [RW-1:0]          rinit_in;
   logic [RW-1:0]          rstep_in;
   logic signed [SB+1:0]   value_in;

   assign n_in         = pass_ff ? DW'(height) : DW'(width);
   assign lines_in     = pass_ff ? DW'(width) : DW'(height);
   assign stride_in    = pass_ff ? AW'(width) : AW'(1);
   assign base_step_in = pass_ff ? AW'(1) : AW'(width);
   assign pix_ok_in    = mem_rdata[SB];
   assign pix_val_in   = mem_rdata[SB-1:0];
   assign diff_in      = {pix_val_in[SB-1], pix_val_in} - {f_ff[SB-1], f_ff};
   assign abs_in       = diff_in[SB] ? -diff_in : diff_in;
   assign last_pos_in  = pos_ff == n_in - 1'b1;
   assign den_in       = LW'(run_len_ff) + 1'b1;
   assign twice_den_in = {1'b0, den_in, 1'b0};
   assign rinit_in     = {1'b0, rem0, 1'b0} + RW'(den_in);
   assign rstep_in     = r_ff + {1'b0, rem0, 1'b0};
   // interpolated value = base +/- rounded magnitude
   assign value_in     = neg_ff ? ({{2{fbase_ff[SB-1]}}, fbase_ff} - $signed({1'b0, q_ff}))
                                : ({{2{fbase_ff[SB-1]}}, fbase_ff} + $signed({1'b0, q_ff}));

   sfi_divider #(.NUM_BITS(SB), .DEN_BITS(LW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (state_ff == S_DIV_START),
      .dividend  (mag_ff),
      .divisor   (den_in),
      .done      (div_done),
      .quotient  (q0),
      .remainder (rem0)
   );

   assign mem_raddr   = addr_ff;
   assign mem_we      = state_ff == S_WR;
   assign mem_waddr   = k_addr_ff;
   assign mem_wdata   = {1'b1, value_in[SB-1:0]};
   assign status.busy = state_ff != S_IDLE;
   assign status.done = state_ff == S_DONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pass_ff   <= 1'b0;
         in_run_ff <= 1'b0;
         has_l_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  pass_ff  <= 1'b0;
                  line_ff  <= '0;
                  base_ff  <= '0;
                  state_ff <= S_LINE_INIT;
               end
            end
            S_LINE_INIT: begin
               pos_ff    <= '0;
               addr_ff   <= base_ff;
               has_l_ff  <= 1'b0;
               in_run_ff <= 1'b0;
               state_ff  <= S_RD;
            end
            S_RD: begin
               state_ff <= S_EV;
            end
            S_EV: begin
               if (pix_ok_in) begin
                  f_ff      <= pix_val_in;
                  has_l_ff  <= 1'b1;
                  in_run_ff <= 1'b0;
                  if (in_run_ff) begin
                     // run closed on the right; copy if no left neighbor
                     fbase_ff    <= has_l_ff ? f_ff : pix_val_in;
                     neg_ff      <= has_l_ff & diff_in[SB];
                     mag_ff      <= has_l_ff ? abs_in[SB-1:0] : '0;
                     end_line_ff <= last_pos_in;
                     state_ff    <= S_DIV_START;
                  end else if (last_pos_in) begin
                     state_ff <= S_LINE_NEXT;
                  end else begin
                     pos_ff   <= pos_ff + 1'b1;
                     addr_ff  <= addr_ff + stride_in;
                     state_ff <= S_RD;
                  end
               end else begin
                  in_run_ff <= 1'b1;
                  if (!in_run_ff) begin
                     run_addr_ff <= addr_ff;
                     run_len_ff  <= DW'(1);
                  end else begin
                     run_len_ff <= run_len_ff + 1'b1;
                  end
                  if (last_pos_in) begin
                     if (has_l_ff) begin
                        // trailing run copies its left neighbor
                        fbase_ff    <= f_ff;
                        neg_ff      <= 1'b0;
                        mag_ff      <= '0;
                        end_line_ff <= 1'b1;
                        state_ff    <= S_DIV_START;
                     end else begin
                        state_ff <= S_LINE_NEXT;
                     end
                  end else begin
                     pos_ff   <= pos_ff + 1'b1;
                     addr_ff  <= addr_ff + stride_in;
                     state_ff <= S_RD;
                  end
               end
            end
            S_DIV_START: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  if (rinit_in >= twice_den_in) begin
                     r_ff <= rinit_in - twice_den_in;
                     q_ff <= {1'b0, q0} + 1'b1;
                  end else begin
                     r_ff <= rinit_in;
                     q_ff <= {1'b0, q0};
                  end
                  k_addr_ff <= run_addr_ff;
                  k_cnt_ff  <= run_len_ff;
                  state_ff  <= S_WR;
               end
            end
            S_WR: begin
               if (rstep_in >= twice_den_in) begin
                  r_ff <= rstep_in - twice_den_in;
                  q_ff <= q_ff + {1'b0, q0} + 1'b1;
               end else begin
                  r_ff <= rstep_in;
                  q_ff <= q_ff + {1'b0, q0};
               end
               k_addr_ff <= k_addr_ff + stride_in;
               k_cnt_ff  <= k_cnt_ff - 1'b1;
               if (k_cnt_ff == DW'(1)) begin
                  if (end_line_ff) begin
                     state_ff <= S_LINE_NEXT;
                  end else begin
                     pos_ff   <= pos_ff + 1'b1;
                     addr_ff  <= addr_ff + stride_in;
                     state_ff <= S_RD;
                  end
               end
            end
            S_LINE_NEXT: begin
               if (line_ff == lines_in - 1'b1) begin
                  if (!pass_ff) begin
                     pass_ff  <= 1'b1;
                     line_ff  <= '0;
                     base_ff  <= '0;
                     state_ff <= S_LINE_INIT;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  line_ff  <= line_ff + 1'b1;
                  base_ff  <= base_ff + base_step_in;
                  state_ff <= S_LINE_INIT;
               end
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule

>>> hdl/separable_hole_fill_interpolator_core.sv
// Top level of the separable hole fill core.
// Loads and fetches are taken one per cycle while busy is low; a load writes the frame store
// in the cycle it is taken, and a fetch answers with one rsp_strobe word in the next cycle, so
// fetches stream at one word per cycle. The load of the last pixel starts the fill, during which
// busy is high and no word is taken: each pass (rows, then columns) scans the store through its
// single read port, runs the bit-serial divider for each hole run next to a valid pixel, writes
// each hole pixel of that run and steps on line by line; the S_DONE state closes the fill.
// The store is not cleared after reset; every pixel is loaded before it is read.
// A configuration write abandons a frame being loaded or fetched; it does not stop a running fill.
module separable_hole_fill_interpolator_core #(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_command,
   input  logic signed [SAMPLE_BITS-1:0]      req_sample,
   input  logic                               req_sample_valid,
   output logic                               rsp_strobe,
   output logic signed [SAMPLE_BITS-1:0]      rsp_filled_value,
   output logic                               rsp_filled_valid,
   output logic                               rsp_last_pixel,
   output logic                               rsp_fetch_error,
   input  logic                               csr_write_enable,
   input  logic [sfi_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sfi_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import sfi_pkg::*;

   localparam int SB      = SAMPLE_BITS;
   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int HW      = $clog2(MAX_HEIGHT + 1);
   localparam int AW      = $clog2(MAX_WIDTH*MAX_HEIGHT);
   localparam int CW      = $clog2(MAX_WIDTH*MAX_HEIGHT + 1);
   localparam int RESET_W = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
   localparam int RESET_H = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;

   function automatic logic [WW-1:0] clamp_w(logic [CSR_DATA_BITS-1:0] v);
      if (v == '0) return WW'(1);
      if (int'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
      return WW'(v);
   endfunction

   function automatic logic [HW-1:0] clamp_h(logic [CSR_DATA_BITS-1:0] v);
      if (v == '0) return HW'(1);
      if (int'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
      return HW'(v);
   endfunction

   logic [WW-1:0]    width_ff;
   logic [HW-1:0]    height_ff;
   logic [CW-1:0]    load_count_ff;
   logic [CW-1:0]    fetch_count_ff;
   logic             ready_ff;
   logic             rsp_strobe_ff;
   logic             rsp_err_ff;
   logic             rsp_last_ff;

   logic [WW+HW-1:0] product_in;
   logic [CW-1:0]    total_in;
   logic             accept_in;
   logic             load_in;
   logic             fetch_in;
   logic [CW-1:0]    lc_in;
   logic [CW-1:0]    lc_next_in;
   logic             fill_start_in;
   logic             fetch_last_in;

   fill_status_type  fill_status;
   logic             eng_we;
   logic [AW-1:0]    eng_waddr;
   logic [SB:0]      eng_wdata;
   logic [AW-1:0]    eng_raddr;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [SB:0]      ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [SB:0]      ram_rdata;

   assign product_in    = width_ff * height_ff;
   assign total_in      = CW'(product_in);
   assign busy          = fill_status.busy;
   assign accept_in     = start & ~busy;
   assign load_in       = accept_in & (req_command == CMD_LOAD);
   assign fetch_in      = accept_in & (req_command == CMD_FETCH);
   assign lc_in         = ready_ff ? '0 : load_count_ff;
   assign lc_next_in    = lc_in + 1'b1;
   assign fill_start_in = load_in & (lc_next_in == total_in);
   assign fetch_last_in = (fetch_count_ff + 1'b1) == total_in;

   assign ram_we    = fill_status.busy ? eng_we : load_in;
   assign ram_waddr = fill_status.busy ? eng_waddr : lc_in[AW-1:0];
   assign ram_wdata = fill_status.busy ? eng_wdata : {req_sample_valid, req_sample};
   assign ram_raddr = fill_status.busy ? eng_raddr : fetch_count_ff[AW-1:0];

   sfi_frame_ram #(.ADDR_BITS(AW), .DATA_BITS(SB + 1)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sfi_fill_engine #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_fill (
      .clock     (clock),
      .reset     (reset),
      .start     (fill_start_in),
      .width     (width_ff),
      .height    (height_ff),
      .status    (fill_status),
      .mem_we    (eng_we),
      .mem_waddr (eng_waddr),
      .mem_wdata (eng_wdata),
      .mem_raddr (eng_raddr),
      .mem_rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff       <= WW'(RESET_W);
         height_ff      <= HW'(RESET_H);
         load_count_ff  <= '0;
         fetch_count_ff <= '0;
         ready_ff       <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         rsp_err_ff     <= 1'b0;
         rsp_last_ff    <= 1'b0;
      end else begin
         rsp_strobe_ff <= fetch_in;
         rsp_err_ff    <= ~ready_ff;
         rsp_last_ff   <= ready_ff & fetch_last_in;
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_IMAGE_WIDTH:  width_ff  <= clamp_w(csr_write_data);
               CSR_IMAGE_HEIGHT: height_ff <= clamp_h(csr_write_data);
            endcase
            load_count_ff  <= '0;
            fetch_count_ff <= '0;
            ready_ff       <= 1'b0;
         end else if (load_in) begin
            // a load on a finished frame starts the next one
            load_count_ff <= lc_next_in;
            if (ready_ff | fill_start_in) begin
               fetch_count_ff <= '0;
            end
            ready_ff <= 1'b0;
         end else if (fetch_in & ready_ff) begin
            fetch_count_ff <= fetch_last_in ? '0 : fetch_count_ff + 1'b1;
         end
         if (fill_status.done) begin
            ready_ff <= 1'b1;
         end
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_fetch_error  = rsp_err_ff;
   assign rsp_last_pixel   = rsp_last_ff;
   assign rsp_filled_valid = ~rsp_err_ff & ram_rdata[SB];
   assign rsp_filled_value = rsp_filled_valid ? ram_rdata[SB-1:0] : '0;
endmodule

>>> hdl/sfi_checker.sv
// Port-level checks of the hole fill core, bound to its top level.
`include "separable_hole_fill_interpolator_core_assert.svh"

module sfi_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   req_command,
   input logic                   rsp_strobe,
   input logic [SAMPLE_BITS-1:0] rsp_filled_value,
   input logic                   rsp_filled_valid
);
   `SFI_ASSERT_NEXT(a_fetch_answered, clock, reset, start && !busy && req_command, rsp_strobe)
   `SFI_ASSERT_IMP(a_word_has_fetch, clock, reset, rsp_strobe, $past(start && !busy && req_command))
   `SFI_ASSERT_IMP(a_hole_reads_zero, clock, reset, rsp_strobe && !rsp_filled_valid, rsp_filled_value == '0)
   `SFI_ASSERT_IMP(a_fill_after_load, clock, reset, $rose(busy), $past(start && !req_command))
endmodule

bind separable_hole_fill_interpolator_core sfi_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_command      (req_command),
   .rsp_strobe       (rsp_strobe),
   .rsp_filled_value (rsp_filled_value),
   .rsp_filled_valid (rsp_filled_valid)
);
